FILE: rtl/fdns_pkg.sv
// Types, character codes and helpers for the declaration name scanner.
package fdns_pkg;

	// Character codes the scanner looks for
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_QUOTE = 8'd34;
	localparam logic [7:0] CH_SLASH = 8'd47;
	localparam logic [7:0] CH_F     = 8'd102;
	localparam logic [7:0] CH_N     = 8'd110;
	localparam logic [7:0] CH_A_LO  = 8'd97;
	localparam logic [7:0] CH_Z_LO  = 8'd122;

	localparam logic [15:0] MAX_NAMES_RST = 16'd512;
	localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

	// Result queue: holds every result one byte can cause
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);

	// Result kinds
	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_END  = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	// Scanner mode, one-hot
	typedef enum logic [3:0] {
		MODE_NORMAL  = 4'b0001,
		MODE_STRING  = 4'b0010,
		MODE_COMMENT = 4'b0100,
		MODE_NAME    = 4'b1000
	} scan_mode_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  ch;
		logic [15:0] idx;
		logic [15:0] tot;
	} res_t;

	function automatic res_t mk_res(kind_t kind, logic [7:0] ch, logic [15:0] idx,
			logic [15:0] tot);
		res_t r;
		r.kind = kind;
		r.ch   = ch;
		r.idx  = idx;
		r.tot  = tot;
		return r;
	endfunction

	// Letter, digit or underscore
	function automatic logic is_ident(logic [7:0] c);
		return (c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90) ||
			(c >= 8'd48 && c <= 8'd57) || c == 8'd95;
	endfunction

endpackage

FILE: rtl/function_decl_name_scanner.sv
// Declaration name scanner: finds "fn <name>" and streams out the declared names.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-----------------------------------------
//  source    | src_valid / src_stall     | src_byte, end_of_text
//  result    | res_valid / res_stall     | kind, name_char, name_index, name_total
//  config    | cfg_valid / cfg_ready     | cfg_data (max_names)
//
// One source byte is taken per cycle while src_stall is low. A byte is held in the input register,
// where one pass of logic updates the scan state and writes up to three results
// into a four-entry result queue that drains one result per cycle while res_stall is low.
// The input stalls only while the queue cannot take all results of the held byte.
// Reset sets max_names to 512 and clears all scan state; no clearing pass.
// A stalled result keeps its payload; cfg_ready is always high.
module function_decl_name_scanner
	import fdns_pkg::*;
#(
	parameter int MAX_NAME_LEN = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	// source bytes
	input  logic        src_valid,
	output logic        src_stall,
	input  logic [7:0]  src_byte,
	input  logic        end_of_text,
	// results
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  kind,
	output logic [7:0]  name_char,
	output logic [15:0] name_index,
	output logic [15:0] name_total,
	// max_names register
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int LEN_W = $clog2(MAX_NAME_LEN + 1);

	// Input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// Scan state
	logic [15:0]      max_names_q;
	scan_mode_t       mode_q;
	logic [7:0]       win_q [3];
	logic [1:0]       fill_q;
	logic [LEN_W-1:0] len_q;
	logic [15:0]      match_cnt_q;
	logic             shown_q;

	// Result queue
	res_t             rq_q [RQ_DEPTH];
	logic [RQ_AW-1:0] rd_ptr_q;
	logic [RQ_AW-1:0] wr_ptr_q;
	logic [RQ_AW:0]   qcount_q;

	// Step logic
	logic [7:0]       wv [4];
	logic [2:0]       f;
	scan_mode_t       md;
	logic [LEN_W-1:0] len;
	logic [15:0]      cnt;
	logic [15:0]      idx;
	logic             shown;
	logic             stop;
	logic             cons;
	res_t             res [RQ_DEPTH];
	logic [RQ_AW:0]   n_res;

	logic             proc;
	logic             pop;

	// One scan step for the held byte
	always_comb begin
		wv[0] = win_q[0];
		wv[1] = win_q[1];
		wv[2] = win_q[2];
		wv[3] = '0;
		f     = {1'b0, fill_q};
		md    = mode_q;
		len   = len_q;
		cnt   = match_cnt_q;
		shown = shown_q;
		idx   = '0;
		stop  = 1'b0;
		cons  = 1'b0;
		n_res = '0;
		for (int i = 0; i < RQ_DEPTH; i++) begin
			res[i] = '0;
		end

		// inside a name: extend it or close it
		if (md == MODE_NAME) begin
			if (is_ident(byte_s1)) begin
				if (len < LEN_W'(MAX_NAME_LEN)) begin
					if (shown) begin
						res[n_res[RQ_AW-1:0]] = mk_res(KIND_CHAR, byte_s1, cnt - 16'd1, cnt);
						n_res = n_res + 1'b1;
					end
					len = len + 1'b1;
				end
			end else begin
				if (shown) begin
					res[n_res[RQ_AW-1:0]] = mk_res(KIND_END, 8'd0, cnt - 16'd1, cnt);
					n_res = n_res + 1'b1;
				end
				md = MODE_NORMAL;
				wv[f[1:0]] = byte_s1;
				f = f + 3'd1;
			end
		end else begin
			wv[f[1:0]] = byte_s1;
			f = f + 3'd1;
		end

		// decide lookahead bytes from the oldest on
		for (int i = 0; i < 4; i++) begin
			if (!stop && f != 3'd0) begin
				cons = 1'b1;
				unique case (md)
					MODE_STRING: begin
						if (wv[0] == CH_QUOTE) md = MODE_NORMAL;
					end
					MODE_COMMENT: begin
						if (wv[0] == CH_NL) md = MODE_NORMAL;
					end
					default: begin
						priority if (wv[0] == CH_F) begin
							if (f != 3'd4) begin
								stop = 1'b1;
								cons = 1'b0;
							end else if (wv[1] == CH_N && wv[2] == CH_SPACE &&
									wv[3] >= CH_A_LO && wv[3] <= CH_Z_LO) begin
								idx   = cnt;
								shown = cnt < max_names_q;
								if (cnt != COUNT_MAX) cnt = cnt + 16'd1;
								if (shown) begin
									res[n_res[RQ_AW-1:0]] = mk_res(KIND_CHAR, wv[3], idx, cnt);
									n_res = n_res + 1'b1;
								end
								len  = LEN_W'(1);
								md   = MODE_NAME;
								f    = 3'd0;
								stop = 1'b1;
								cons = 1'b0;
							end
						end else if (wv[0] == CH_QUOTE) begin
							md = MODE_STRING;
						end else if (wv[0] == CH_SLASH) begin
							if (f < 3'd2) begin
								stop = 1'b1;
								cons = 1'b0;
							end else if (wv[1] == CH_SLASH) begin
								md = MODE_COMMENT;
							end
						end else begin
							cons = 1'b1;
						end
					end
				endcase
				if (cons) begin
					wv[0] = wv[1];
					wv[1] = wv[2];
					wv[2] = wv[3];
					wv[3] = '0;
					f = f - 3'd1;
				end
			end
		end

		// end of text: close an open name, report the count
		if (last_s1) begin
			if (md == MODE_NAME && shown) begin
				res[n_res[RQ_AW-1:0]] = mk_res(KIND_END, 8'd0, cnt - 16'd1, cnt);
				n_res = n_res + 1'b1;
			end
			res[n_res[RQ_AW-1:0]] = mk_res(KIND_DONE, 8'd0, 16'd0, cnt);
			n_res = n_res + 1'b1;
		end
	end

	// Handshakes
	assign proc      = valid_s1 && ((4'(qcount_q) + 4'(n_res)) <= 4'(RQ_DEPTH));
	assign src_stall = valid_s1 && !proc;
	assign res_valid = qcount_q != '0;
	assign pop       = res_valid && !res_stall;
	assign cfg_ready = 1'b1;

	// Result payload from queue head
	assign kind       = rq_q[rd_ptr_q].kind;
	assign name_char  = rq_q[rd_ptr_q].ch;
	assign name_index = rq_q[rd_ptr_q].idx;
	assign name_total = rq_q[rd_ptr_q].tot;

	// Input register and queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			qcount_q <= '0;
		end else begin
			if (src_valid && !src_stall) begin
				valid_s1 <= 1'b1;
			end else if (proc) begin
				valid_s1 <= 1'b0;
			end
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (proc) wr_ptr_q <= wr_ptr_q + n_res[RQ_AW-1:0];
			qcount_q <= qcount_q + (proc ? n_res : '0) - {{RQ_AW{1'b0}}, pop};
		end
	end

	// Input payload
	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			byte_s1 <= src_byte;
			last_s1 <= end_of_text;
		end
	end

	// Queue entries
	always_ff @(posedge clk) begin
		for (int i = 0; i < RQ_DEPTH; i++) begin
			if (proc && (RQ_AW + 1)'(i) < n_res) begin
				rq_q[wr_ptr_q + RQ_AW'(i)] <= res[i];
			end
		end
	end

	// Scan state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_names_q <= MAX_NAMES_RST;
			mode_q      <= MODE_NORMAL;
			win_q[0]    <= '0;
			win_q[1]    <= '0;
			win_q[2]    <= '0;
			fill_q      <= '0;
			len_q       <= '0;
			match_cnt_q <= '0;
			shown_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) max_names_q <= cfg_data;
			if (proc) begin
				if (last_s1) begin
					mode_q      <= MODE_NORMAL;
					win_q[0]    <= '0;
					win_q[1]    <= '0;
					win_q[2]    <= '0;
					fill_q      <= '0;
					len_q       <= '0;
					match_cnt_q <= '0;
					shown_q     <= 1'b0;
				end else begin
					mode_q      <= md;
					win_q[0]    <= wv[0];
					win_q[1]    <= wv[1];
					win_q[2]    <= wv[2];
					fill_q      <= f[1:0];
					len_q       <= len;
					match_cnt_q <= cnt;
					shown_q     <= shown;
				end
			end
		end
	end

	// Checks
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcount_q <= (RQ_AW + 1)'(RQ_DEPTH))
		else $error("result queue overfilled");

	a_stall_only_when_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !proc) |-> qcount_q != '0)
		else $error("source stalled with an empty result queue");

	a_name_no_lookahead: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_NAME |-> fill_q == '0)
		else $error("lookahead bytes held inside a name");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && last_s1) |=> (match_cnt_q == '0 && mode_q == MODE_NORMAL && fill_q == '0))
		else $error("scan state not cleared after end of text");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_NAME_LEN))
		else $error("name length above limit");

endmodule
